@@ design/bale_pkg.sv @@
// Shared types and codes for the bounded array list engine.
`timescale 1ns / 1ps

package bale_pkg;

    // Operation codes
    localparam logic [2:0] OP_CLEAR         = 3'd0;
    localparam logic [2:0] OP_INSERT_AT     = 3'd1;
    localparam logic [2:0] OP_INSERT_SORTED = 3'd2;
    localparam logic [2:0] OP_READ_AT       = 3'd3;
    localparam logic [2:0] OP_POP_TAIL      = 3'd4;
    localparam logic [2:0] OP_DELETE_AT     = 3'd5;
    localparam logic [2:0] OP_LOCATE        = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         index;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value_out;
        logic [6:0]         position;
        logic [7:0]         length;
    } rsp_t;

endpackage

@@ design/bounded_array_list_engine_core.sv @@
// Bounded array list engine: list storage in one memory and its sequencer.
// Clear, failing and unused requests pass through decode to the response step; read and pop
// also fetch from memory; sorted insert scans, inserts shift up, delete shifts down, locate scans.
// Shifts and scans are paced by the single read and single write port of the entry memory:
// they move one entry per cycle. One request is in work at a time.
// Reset clears the count and the control state; the entry memory is not initialized.
`timescale 1ns / 1ps

module bounded_array_list_engine_core #(
    parameter int CAPACITY    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  bale_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bale_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_SHUP   = 8'b0000_1000,
        S_PUT    = 8'b0001_0000,
        S_FETCH  = 8'b0010_0000,
        S_SHDN   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [2:0]             op_reg, op_next;
    logic [6:0]             idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [2:0]             status_reg, status_next;
    logic [VALUE_WIDTH-1:0] vout_reg, vout_next;
    bale_pkg::rsp_t         rsp_reg, rsp_next;

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rsp_load;

    logic [XW-1:0]          idx_x;
    logic [XW-1:0]          cnt_x;
    logic [AW-1:0]          idx_a;
    logic [AW-1:0]          tail_a;

    assign idx_x  = XW'(idx_reg);
    assign cnt_x  = XW'(cnt_reg);
    assign idx_a  = AW'(idx_x);
    assign tail_a = AW'(cnt_reg - CW'(1));

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequence each request through the memory
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = rd_data_reg;
        rsp_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Capture the request on transfer
                if (req_valid)
                begin
                    op_next    = req.operation;
                    idx_next   = req.index;
                    val_next   = VALUE_WIDTH'(unsigned'(req.value));
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = bale_pkg::ST_OK;
                vout_next   = '0;
                pos_next    = '0;
                state_next  = S_RESP;
                unique case (op_reg)
                    bale_pkg::OP_CLEAR:
                    begin
                        cnt_next = '0;
                    end
                    bale_pkg::OP_INSERT_AT:
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else if (idx_x > cnt_x)
                        begin
                            status_next = bale_pkg::ST_RANGE;
                        end
                        else if (idx_x == cnt_x)
                        begin
                            pos_next   = idx_a;
                            state_next = S_PUT;
                        end
                        else
                        begin
                            pos_next   = idx_a;
                            rd_en      = 1'b1;
                            rd_addr    = tail_a;
                            ptr_next   = tail_a;
                            state_next = S_SHUP;
                        end
                    end
                    bale_pkg::OP_INSERT_SORTED:
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            status_next = bale_pkg::ST_FULL;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    bale_pkg::OP_READ_AT:
                    begin
                        if (idx_x >= cnt_x)
                        begin
                            status_next = bale_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_a;
                            state_next = S_FETCH;
                        end
                    end
                    bale_pkg::OP_POP_TAIL:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = tail_a;
                            state_next = S_FETCH;
                        end
                    end
                    bale_pkg::OP_DELETE_AT:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = bale_pkg::ST_EMPTY;
                        end
                        else if (idx_x >= cnt_x)
                        begin
                            status_next = bale_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_a;
                            state_next = S_FETCH;
                        end
                    end
                    bale_pkg::OP_LOCATE:
                    begin
                        status_next = bale_pkg::ST_NOT_FOUND;
                        if (cnt_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SCAN:
            begin
                // Walk the list from the head, one entry per cycle
                if (op_reg == bale_pkg::OP_LOCATE)
                begin
                    if (rd_data_reg == val_reg)
                    begin
                        status_next = bale_pkg::ST_OK;
                        pos_next    = ptr_reg;
                        state_next  = S_RESP;
                    end
                    else if (CW'(ptr_reg) + CW'(1) == cnt_reg)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg + AW'(1);
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    if (!($signed(rd_data_reg) < $signed(val_reg)))
                    begin
                        pos_next   = ptr_reg;
                        rd_en      = 1'b1;
                        rd_addr    = tail_a;
                        ptr_next   = tail_a;
                        state_next = S_SHUP;
                    end
                    else if (CW'(ptr_reg) + CW'(1) == cnt_reg)
                    begin
                        pos_next   = AW'(cnt_reg);
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg + AW'(1);
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end

            S_SHUP:
            begin
                // Move entry up one place, tail first
                wr_en   = 1'b1;
                wr_addr = ptr_reg + AW'(1);
                wr_data = rd_data_reg;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - AW'(1);
                    ptr_next = ptr_reg - AW'(1);
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_RESP;
            end

            S_FETCH:
            begin
                vout_next = rd_data_reg;
                if (op_reg == bale_pkg::OP_READ_AT)
                begin
                    state_next = S_RESP;
                end
                else if ((op_reg == bale_pkg::OP_DELETE_AT) &&
                         (CW'(idx_a) + CW'(1) < cnt_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_a + AW'(1);
                    ptr_next   = idx_a;
                    state_next = S_SHDN;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_SHDN:
            begin
                // Move entry down one place, head first
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data_reg;
                if (CW'(ptr_reg) + CW'(2) >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(2);
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_RESP:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Build the result
    always_comb
    begin
        rsp_next.status    = status_reg;
        rsp_next.value_out = 32'(vout_reg);
        rsp_next.position  = 7'(pos_reg);
        rsp_next.length    = 8'(cnt_reg);
    end

    // Output valid: set on load, drop after transfer
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same entry in one cycle");

    a_shift_up_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHUP) |-> (ptr_reg >= pos_reg))
        else $error("shift up pointer passed the insert position");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response step");
`endif

endmodule

@@ tb/tb_bounded_array_list_engine_core.sv @@
// Self-checking testbench for the bounded array list engine core.
`timescale 1ns / 1ps

module tb_bounded_array_list_engine_core;

    localparam int LIST_CAP       = 128;
    localparam int TOTAL_ITEMS    = 420;
    localparam int FILL_AFTER     = 80;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 600;
    localparam int QUIET_FROM     = 300;
    localparam int QUIET_TO       = 380;
    localparam int SETTLE_CYCLES  = 20;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    bale_pkg::req_t req = '0;
    bale_pkg::rsp_t rsp;

    // Stimulus waiting for transfer, and results owed by the block
    bale_pkg::req_t pending_reqs[$];
    bale_pkg::rsp_t owed_rsps[$];

    // Mirror of the list contents
    logic signed [31:0] list_mem[LIST_CAP];
    int                 list_len = 0;

    // Length the stimulus generator assumes, used to aim indexes and to size the fill
    int gen_len      = 0;
    int queued_count = 0;

    int sent_count   = 0;
    int got_count    = 0;
    int error_count  = 0;
    int cycle_count  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    logic signed [31:0] value_pool[8] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
        32'sh0001_0000, 32'shFFFF_0000, 32'sh0064_0000, 32'sh0000_0001
    };

    bounded_array_list_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // Shift entries up from a slot and write the new value there
    function automatic void open_slot(int at, logic signed [31:0] v);
        int k;
        for (k = list_len; k > at; k--)
            list_mem[k] = list_mem[k - 1];
        list_mem[at] = v;
        list_len++;
    endfunction

    // Remove the entry at a slot and shift later entries down
    function automatic logic signed [31:0] close_slot(int at);
        logic signed [31:0] taken;
        int                 k;
        taken = list_mem[at];
        for (k = at; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k + 1];
        list_len--;
        return taken;
    endfunction

    // Apply one request to the mirror and build the response it must produce
    function automatic bale_pkg::rsp_t predict_response(bale_pkg::req_t r);
        bale_pkg::rsp_t     o;
        int                 idx;
        int                 slot;
        int                 k;
        bit                 found;
        logic signed [31:0] v;
        o     = '0;
        idx   = r.index;
        v     = $signed(r.value);
        found = 1'b0;
        o.status = bale_pkg::ST_OK;
        case (r.operation)
            bale_pkg::OP_CLEAR:
                list_len = 0;
            bale_pkg::OP_INSERT_AT:
                if (list_len >= LIST_CAP)
                    o.status = bale_pkg::ST_FULL;
                else if (idx > list_len)
                    o.status = bale_pkg::ST_RANGE;
                else
                begin
                    open_slot(idx, v);
                    o.position = r.index;
                end
            bale_pkg::OP_INSERT_SORTED:
                if (list_len >= LIST_CAP)
                    o.status = bale_pkg::ST_FULL;
                else
                begin
                    slot = 0;
                    while (slot < list_len && list_mem[slot] < v)
                        slot++;
                    open_slot(slot, v);
                    o.position = slot[6:0];
                end
            bale_pkg::OP_READ_AT:
                if (idx >= list_len)
                    o.status = bale_pkg::ST_RANGE;
                else
                    o.value_out = list_mem[idx];
            bale_pkg::OP_POP_TAIL:
                if (list_len == 0)
                    o.status = bale_pkg::ST_EMPTY;
                else
                    o.value_out = close_slot(list_len - 1);
            bale_pkg::OP_DELETE_AT:
                if (list_len == 0)
                    o.status = bale_pkg::ST_EMPTY;
                else if (idx >= list_len)
                    o.status = bale_pkg::ST_RANGE;
                else
                    o.value_out = close_slot(idx);
            bale_pkg::OP_LOCATE:
            begin
                o.status = bale_pkg::ST_NOT_FOUND;
                for (k = 0; k < list_len && !found; k++)
                begin
                    if (list_mem[k] == v)
                    begin
                        found      = 1'b1;
                        o.status   = bale_pkg::ST_OK;
                        o.position = k[6:0];
                    end
                end
            end
            default:
                ;
        endcase
        o.length = list_len[7:0];
        return o;
    endfunction

    function automatic bale_pkg::req_t make_req(logic [2:0] op, int idx, logic [31:0] v);
        bale_pkg::req_t r;
        r.operation = op;
        r.index     = idx[6:0];
        r.value     = v;
        return r;
    endfunction

    // Draw a value: often from the pool so that locates hit and duplicates occur
    function automatic logic [31:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Index aimed at live entries, with some drawn over the full field
    function automatic int pick_index(int span);
        if (span <= 0 || $urandom_range(99) < 15)
            return $urandom_range(127);
        return $urandom_range(span - 1);
    endfunction

    // Queue one request and track the length it leaves behind
    task automatic queue_req(bale_pkg::req_t r);
        int idx;
        idx = r.index;
        pending_reqs.push_back(r);
        queued_count++;
        case (r.operation)
            bale_pkg::OP_CLEAR:         gen_len = 0;
            bale_pkg::OP_INSERT_AT:     if (gen_len < LIST_CAP && idx <= gen_len) gen_len++;
            bale_pkg::OP_INSERT_SORTED: if (gen_len < LIST_CAP) gen_len++;
            bale_pkg::OP_POP_TAIL:      if (gen_len > 0) gen_len--;
            bale_pkg::OP_DELETE_AT:     if (gen_len > 0 && idx < gen_len) gen_len--;
            default:                    ;
        endcase
    endtask

    // Block until the sender is empty and every owed response has arrived
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: predict on each transfer, then offer the next item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                owed_rsps.push_back(predict_response(req));
                sent_count++;
            end
            // Hold a stalled item; otherwise offer the next one or idle
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 &&
                    ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                     $urandom_range(99) >= 7))
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each transfer, then choose the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got_count++;
                if (owed_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response status %0d value %0h pos %0d len %0d",
                             $time, rsp.status, rsp.value_out, rsp.position, rsp.length);
                    error_count++;
                end
                else
                begin
                    automatic bale_pkg::rsp_t want = owed_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.value_out !== want.value_out)
                    begin
                        $display("%0t: value_out mismatch: expected %0h, actual %0h",
                                 $time, want.value_out, rsp.value_out);
                        error_count++;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, rsp.position);
                        error_count++;
                    end
                    if (rsp.length !== want.length)
                    begin
                        $display("%0t: length mismatch: expected %0d, actual %0d",
                                 $time, want.length, rsp.length);
                        error_count++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up its input
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && got_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else if (got_count >= QUIET_FROM && got_count < QUIET_TO)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < 7);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int roll;
        int k;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list errors, extremes, append, duplicates, unused code
        queue_req(make_req(bale_pkg::OP_POP_TAIL, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_DELETE_AT, 127, 32'h0));
        queue_req(make_req(bale_pkg::OP_READ_AT, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_LOCATE, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_INSERT_AT, 1, 32'h1234));
        queue_req(make_req(bale_pkg::OP_INSERT_AT, 0, VAL_MAX));
        queue_req(make_req(bale_pkg::OP_INSERT_SORTED, 0, VAL_MIN));
        queue_req(make_req(bale_pkg::OP_INSERT_SORTED, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_INSERT_AT, 3, 32'hFFFF_FFFF));
        queue_req(make_req(bale_pkg::OP_INSERT_SORTED, 127, 32'h0));
        queue_req(make_req(bale_pkg::OP_READ_AT, 127, 32'h0));
        queue_req(make_req(bale_pkg::OP_READ_AT, 4, 32'h0));
        queue_req(make_req(bale_pkg::OP_LOCATE, 0, 32'hFFFF_FFFF));
        queue_req(make_req(bale_pkg::OP_LOCATE, 0, VAL_MAX));
        queue_req(make_req(bale_pkg::OP_LOCATE, 0, 32'h1234_5678));
        queue_req(make_req(bale_pkg::OP_DELETE_AT, 5, 32'h0));
        queue_req(make_req(bale_pkg::OP_DELETE_AT, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_POP_TAIL, 0, 32'h0));
        queue_req(make_req(OP_UNUSED, 127, 32'hFFFF_FFFF));
        queue_req(make_req(bale_pkg::OP_READ_AT, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_CLEAR, 127, 32'hFFFF_FFFF));
        queue_req(make_req(bale_pkg::OP_READ_AT, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_POP_TAIL, 0, 32'h0));
        queue_req(make_req(bale_pkg::OP_INSERT_AT, 0, 32'h0064_0000));

        // Pause the sender until every owed response is back
        wait_drained();

        // Random: mixed operations, with one fill to capacity along the way
        while (queued_count < TOTAL_ITEMS)
        begin
            roll = $urandom_range(99);
            if (queued_count >= FILL_AFTER && queued_count < FILL_AFTER + 5)
            begin
                queue_req(make_req(bale_pkg::OP_CLEAR, $urandom_range(127), $urandom));
                while (gen_len < LIST_CAP)
                begin
                    if ($urandom_range(99) < 70)
                        queue_req(make_req(bale_pkg::OP_INSERT_SORTED, $urandom_range(127),
                                           pick_value()));
                    else
                        queue_req(make_req(bale_pkg::OP_INSERT_AT, $urandom_range(gen_len),
                                           pick_value()));
                end
                // Inserts into a full list, then a read at the top end, a search, and deletes and an insert at the ends
                for (k = 0; k < 3; k++)
                begin
                    queue_req(make_req(bale_pkg::OP_INSERT_SORTED, 0, pick_value()));
                    queue_req(make_req(bale_pkg::OP_INSERT_AT, $urandom_range(127),
                                       pick_value()));
                end
                queue_req(make_req(bale_pkg::OP_READ_AT, 127, 32'h0));
                queue_req(make_req(bale_pkg::OP_LOCATE, 0, pick_value()));
                queue_req(make_req(bale_pkg::OP_DELETE_AT, 0, 32'h0));
                queue_req(make_req(bale_pkg::OP_INSERT_AT, 127, pick_value()));
                queue_req(make_req(bale_pkg::OP_DELETE_AT, 127, 32'h0));
            end
            else if (roll < 6)
                queue_req(make_req(bale_pkg::OP_CLEAR, $urandom_range(127), $urandom));
            else if (roll < 28)
                queue_req(make_req(bale_pkg::OP_INSERT_AT, pick_index(gen_len + 1),
                                   pick_value()));
            else if (roll < 48)
                queue_req(make_req(bale_pkg::OP_INSERT_SORTED, $urandom_range(127),
                                   pick_value()));
            else if (roll < 63)
                queue_req(make_req(bale_pkg::OP_READ_AT, pick_index(gen_len), $urandom));
            else if (roll < 73)
                queue_req(make_req(bale_pkg::OP_POP_TAIL, $urandom_range(127), $urandom));
            else if (roll < 85)
                queue_req(make_req(bale_pkg::OP_DELETE_AT, pick_index(gen_len), $urandom));
            else if (roll < 97)
                queue_req(make_req(bale_pkg::OP_LOCATE, $urandom_range(127), pick_value()));
            else
                queue_req(make_req(OP_UNUSED, $urandom_range(127), $urandom));
        end

        // Drain, then watch a little longer for stray responses
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
design/bale_pkg.sv
design/bounded_array_list_engine_core.sv
tb/tb_bounded_array_list_engine_core.sv
